// File: hdl/lzcns_pkg.sv
package lzcns_pkg;

  localparam int unsigned DEF_IN_WIDTH  = 32;
  localparam int unsigned DEF_OUT_WIDTH = 24;

  localparam int unsigned MODE_WIDTH = 2;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_ZEROS  = 2'd0,
    MODE_ONES   = 2'd1,
    MODE_SELECT = 2'd2
  } count_mode_e;

  typedef struct packed {
    logic valid;
  } stage_ctrl_t;

endpackage

// File: hdl/lzcns_norm_stage.sv
module lzcns_norm_stage #(
  parameter int unsigned IN_WIDTH  = lzcns_pkg::DEF_IN_WIDTH,
  parameter int unsigned CNT_WIDTH = $clog2(IN_WIDTH + 1),
  parameter int unsigned PAD_WIDTH = 1 << CNT_WIDTH,
  parameter int unsigned LVL_HI    = CNT_WIDTH - 1,
  parameter int unsigned LVL_LO    = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lzcns_pkg::stage_ctrl_t     ctrl_i,
  input  logic [IN_WIDTH-1:0]        data_i,
  input  logic [PAD_WIDTH-1:0]       match_i,
  input  logic [CNT_WIDTH-1:0]       cnt_i,
  output lzcns_pkg::stage_ctrl_t     ctrl_o,
  output logic [IN_WIDTH-1:0]        data_o,
  output logic [PAD_WIDTH-1:0]       match_o,
  output logic [CNT_WIDTH-1:0]       cnt_o
);

  localparam int unsigned NLVL = LVL_HI - LVL_LO + 1;

  logic [IN_WIDTH-1:0]  data_c  [NLVL+1];
  logic [PAD_WIDTH-1:0] match_c [NLVL+1];
  logic [CNT_WIDTH-1:0] cnt_c   [NLVL+1];

  lzcns_pkg::stage_ctrl_t ctrl_q;
  logic [IN_WIDTH-1:0]    data_q;
  logic [PAD_WIDTH-1:0]   match_q;
  logic [CNT_WIDTH-1:0]   cnt_q;

  assign data_c[0]  = data_i;
  assign match_c[0] = match_i;
  assign cnt_c[0]   = cnt_i;

  for (genvar g = 0; g < NLVL; g++) begin : g_lvl
    localparam int unsigned LVL = LVL_HI - g;
    localparam int unsigned SH  = 1 << LVL;
    logic hit;
    assign hit = ~|match_c[g][PAD_WIDTH-1 -: SH];
    assign data_c[g+1]  = hit ? (data_c[g] << SH) : data_c[g];
    assign match_c[g+1] = hit ? (match_c[g] << SH) : match_c[g];
    assign cnt_c[g+1]   = cnt_c[g] | (CNT_WIDTH'(hit) << LVL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_c[NLVL];
    match_q <= match_c[NLVL];
    cnt_q   <= cnt_c[NLVL];
  end

  assign ctrl_o  = ctrl_q;
  assign data_o  = data_q;
  assign match_o = match_q;
  assign cnt_o   = cnt_q;

endmodule

// File: hdl/leading_zero_one_count_normalize_sticky.sv
// Leading zero/one counter with normalizing shifter and sticky bit.
//
// Input transaction: data_in_i and ones_select_i are taken at a rising edge
// where start_i is high and busy_o is low. busy_o is always low, so a new
// transaction may be started in every cycle.
// Result transaction: lead_count_o, normalized_o and sticky_o are valid for
// exactly one cycle while done_o is high; the receiver must take them then.
// Pipeline: a transaction passes four register stages (input, upper shift
// levels, lower shift levels, output window) between start_i and done_o.
// Throughput is one transaction per cycle.
// The count and normalizing shift run as a log2 ladder of shift levels,
// split over two stages; that ladder sets the stage depth.
// Configuration: cfg_we_i writes cfg_data_i into count_mode (0 zeros,
// 1 ones, 2 or 3 per-transaction choice from ones_select_i). Write it only
// while no transaction is in flight.
// Reset: clears all stage valid bits and sets count_mode to 2. No clearing
// pass is needed; the block keeps no state beyond the pipeline and count_mode.
module leading_zero_one_count_normalize_sticky #(
  parameter int unsigned IN_WIDTH  = lzcns_pkg::DEF_IN_WIDTH,
  parameter int unsigned OUT_WIDTH = lzcns_pkg::DEF_OUT_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lzcns_pkg::MODE_WIDTH-1:0]    cfg_data_i,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [IN_WIDTH-1:0]                 data_in_i,
  input  logic                                ones_select_i,
  output logic                                done_o,
  output logic [$clog2(IN_WIDTH+1)-1:0]       lead_count_o,
  output logic [OUT_WIDTH-1:0]                normalized_o,
  output logic                                sticky_o
);

  localparam int unsigned CNT_WIDTH = $clog2(IN_WIDTH + 1);
  localparam int unsigned PAD_WIDTH = 1 << CNT_WIDTH;
  localparam int unsigned SPLIT     = CNT_WIDTH / 2;
  localparam logic [PAD_WIDTH-1:0] SENTINEL =
    PAD_WIDTH'(1) << (PAD_WIDTH - IN_WIDTH - 1);

  lzcns_pkg::count_mode_e count_mode_q, count_mode_d;
  logic                   target;
  logic [IN_WIDTH-1:0]    flip;

  lzcns_pkg::stage_ctrl_t ctrl0_q, ctrl1, ctrl2, ctrl3_q;
  logic [IN_WIDTH-1:0]    data0_q, data1, data2;
  logic [PAD_WIDTH-1:0]   match0_q, match1, match2;
  logic [CNT_WIDTH-1:0]   cnt1, cnt2, cnt3_q;
  logic [OUT_WIDTH-1:0]   norm_d, norm_q;
  logic                   sticky_d, sticky_q;

  assign busy_o = 1'b0;

  always_comb begin
    count_mode_d = count_mode_q;
    if (cfg_we_i) begin
      count_mode_d = lzcns_pkg::count_mode_e'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_mode_q <= lzcns_pkg::MODE_SELECT;
    end else begin
      count_mode_q <= count_mode_d;
    end
  end

  always_comb begin
    case (count_mode_q)
      lzcns_pkg::MODE_ZEROS: target = 1'b0;
      lzcns_pkg::MODE_ONES:  target = 1'b1;
      default:               target = ones_select_i;
    endcase
  end

  assign flip = data_in_i ^ {IN_WIDTH{target}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl0_q <= '0;
      ctrl3_q <= '0;
    end else begin
      ctrl0_q.valid <= start_i & ~busy_o;
      ctrl3_q       <= ctrl2;
    end
  end

  always_ff @(posedge clk_i) begin
    data0_q  <= data_in_i;
    match0_q <= {flip, {(PAD_WIDTH - IN_WIDTH){1'b0}}} | SENTINEL;
  end

  lzcns_norm_stage #(
    .IN_WIDTH  (IN_WIDTH),
    .CNT_WIDTH (CNT_WIDTH),
    .PAD_WIDTH (PAD_WIDTH),
    .LVL_HI    (CNT_WIDTH - 1),
    .LVL_LO    (SPLIT)
  ) u_stage_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl0_q),
    .data_i  (data0_q),
    .match_i (match0_q),
    .cnt_i   ('0),
    .ctrl_o  (ctrl1),
    .data_o  (data1),
    .match_o (match1),
    .cnt_o   (cnt1)
  );

  lzcns_norm_stage #(
    .IN_WIDTH  (IN_WIDTH),
    .CNT_WIDTH (CNT_WIDTH),
    .PAD_WIDTH (PAD_WIDTH),
    .LVL_HI    (SPLIT - 1),
    .LVL_LO    (0)
  ) u_stage_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl1),
    .data_i  (data1),
    .match_i (match1),
    .cnt_i   (cnt1),
    .ctrl_o  (ctrl2),
    .data_o  (data2),
    .match_o (match2),
    .cnt_o   (cnt2)
  );

  if (OUT_WIDTH >= IN_WIDTH) begin : g_pad
    assign norm_d   = OUT_WIDTH'({data2, {(OUT_WIDTH - IN_WIDTH + 1){1'b0}}} >> 1);
    assign sticky_d = 1'b0;
  end else begin : g_drop
    assign norm_d   = data2[IN_WIDTH-1 -: OUT_WIDTH];
    assign sticky_d = |data2[IN_WIDTH-OUT_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    cnt3_q   <= cnt2;
    norm_q   <= norm_d;
    sticky_q <= sticky_d;
  end

  assign done_o       = ctrl3_q.valid;
  assign lead_count_o = cnt3_q;
  assign normalized_o = norm_q;
  assign sticky_o     = sticky_q;

endmodule

// File: sim/leading_zero_one_count_normalize_sticky_test.sv
`timescale 1ns / 100ps

module leading_zero_one_count_normalize_sticky_test;

  localparam int unsigned IN_W  = lzcns_pkg::DEF_IN_WIDTH;
  localparam int unsigned OUT_W = lzcns_pkg::DEF_OUT_WIDTH;
  localparam int unsigned CNT_W = $clog2(IN_W + 1);
  localparam int unsigned DROP_W = IN_W - OUT_W;
  localparam logic [lzcns_pkg::MODE_WIDTH-1:0] MODE_SELECT_ALIAS = 2'd3;
  localparam int unsigned IDLE_PCT = 33;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [CNT_W-1:0] lead_count;
    logic [OUT_W-1:0] normalized;
    logic             sticky;
  } norm_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [lzcns_pkg::MODE_WIDTH-1:0] cfg_data_i = '0;
  logic                             start_i = 1'b0;
  logic                             busy_o;
  logic [IN_W-1:0]                  data_in_i = '0;
  logic                             ones_select_i = 1'b0;
  logic                             done_o;
  logic [CNT_W-1:0]                 lead_count_o;
  logic [OUT_W-1:0]                 normalized_o;
  logic                             sticky_o;

  norm_result_t                     pending_norm_q[$];
  norm_result_t                     want_res;
  logic [lzcns_pkg::MODE_WIDTH-1:0] count_mode = lzcns_pkg::MODE_SELECT;
  bit                               idle_off = 1'b0;
  int                               errors = 0;
  int                               words_sent = 0;
  int                               results_checked = 0;
  int                               mode_writes = 0;

  leading_zero_one_count_normalize_sticky #(
    .IN_WIDTH (IN_W),
    .OUT_WIDTH(OUT_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .data_in_i    (data_in_i),
    .ones_select_i(ones_select_i),
    .done_o       (done_o),
    .lead_count_o (lead_count_o),
    .normalized_o (normalized_o),
    .sticky_o     (sticky_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("%0t: timeout, %0d results still pending", $time, pending_norm_q.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic norm_result_t predict_norm(input logic [IN_W-1:0] word,
                                                input logic sel,
                                                input logic [lzcns_pkg::MODE_WIDTH-1:0] mode);
    norm_result_t    r;
    logic            target;
    logic            run;
    logic [IN_W-1:0] shifted;
    int              cnt;
    int              i;
    if (mode == lzcns_pkg::MODE_ZEROS) begin
      target = 1'b0;
    end else if (mode == lzcns_pkg::MODE_ONES) begin
      target = 1'b1;
    end else begin
      target = sel;
    end
    cnt = 0;
    run = 1'b1;
    for (i = IN_W - 1; i >= 0; i--) begin
      if (run && word[i] == target) begin
        cnt++;
      end else begin
        run = 1'b0;
      end
    end
    shifted = (cnt >= IN_W) ? '0 : (word << cnt);
    r.lead_count = cnt[CNT_W-1:0];
    r.normalized = shifted[IN_W-1 -: OUT_W];
    r.sticky     = |shifted[DROP_W-1:0];
    return r;
  endfunction

  // Random word with a chosen run of leading bits, then the opposite bit.
  function automatic logic [IN_W-1:0] shaped_word(input logic lead);
    logic [IN_W-1:0] w;
    logic [IN_W-1:0] mask;
    int              n;
    n = $urandom_range(IN_W, 0);
    w = $urandom;
    mask = (n == 0) ? '0 : ({IN_W{1'b1}} << (IN_W - n));
    w = lead ? (w | mask) : (w & ~mask);
    if (n < IN_W) begin
      w[IN_W - 1 - n] = ~lead;
    end
    if ($urandom_range(2, 0) == 0) begin
      w[DROP_W-1:0] = '0;
    end
    return w;
  endfunction

  task automatic send_word(input logic [IN_W-1:0] word, input logic sel);
    while (!idle_off && $urandom_range(99, 0) < IDLE_PCT) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    data_in_i     <= word;
    ones_select_i <= sel;
    do @(posedge clk_i); while (busy_o);
    pending_norm_q.push_back(predict_norm(word, sel, count_mode));
    words_sent++;
  endtask

  task automatic write_mode(input logic [lzcns_pkg::MODE_WIDTH-1:0] mode);
    start_i <= 1'b0;
    while (pending_norm_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    count_mode = mode;
    mode_writes++;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_default();
    logic [IN_W-1:0] edge_words[9];
    int              k;
    edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h0000_0100, 32'h0000_00FF, 32'hFFFF_FF00,
                   32'h0080_0001};
    for (k = 0; k < 9; k++) begin
      send_word(edge_words[k], 1'b0);
      send_word(edge_words[k], 1'b1);
    end
  endtask

  task automatic test_fixed_modes();
    write_mode(lzcns_pkg::MODE_ZEROS);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h0000_0001, 1'b1);
    write_mode(lzcns_pkg::MODE_ONES);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFE, 1'b0);
    write_mode(MODE_SELECT_ALIAS);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_random_words(input logic [lzcns_pkg::MODE_WIDTH-1:0] mode, input int n,
                                   input bit quiet);
    logic sel;
    logic lead;
    int   k;
    write_mode(mode);
    idle_off = quiet;
    for (k = 0; k < n; k++) begin
      sel = 1'($urandom_range(1, 0));
      if (mode == lzcns_pkg::MODE_ZEROS) begin
        lead = 1'b0;
      end else if (mode == lzcns_pkg::MODE_ONES) begin
        lead = 1'b1;
      end else begin
        lead = sel;
      end
      if ($urandom_range(9, 0) < 3) begin
        send_word($urandom, sel);
      end else begin
        send_word(shaped_word(lead), sel);
      end
    end
    idle_off = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_norm_q.size() == 0) begin
        $display("%0t: result with nothing pending: count %0d norm %h sticky %b",
                 $time, lead_count_o, normalized_o, sticky_o);
        errors++;
      end else begin
        want_res = pending_norm_q.pop_front();
        if (lead_count_o !== want_res.lead_count) begin
          $display("%0t: lead_count expected %0d actual %0d",
                   $time, want_res.lead_count, lead_count_o);
          errors++;
        end
        if (normalized_o !== want_res.normalized) begin
          $display("%0t: normalized expected %h actual %h",
                   $time, want_res.normalized, normalized_o);
          errors++;
        end
        if (sticky_o !== want_res.sticky) begin
          $display("%0t: sticky expected %b actual %b", $time, want_res.sticky, sticky_o);
          errors++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_default();
    test_fixed_modes();
    test_random_words(lzcns_pkg::MODE_ZEROS, 300, 1'b0);
    test_random_words(lzcns_pkg::MODE_ONES, 300, 1'b0);
    test_random_words(lzcns_pkg::MODE_SELECT, 300, 1'b1);
    test_random_words(MODE_SELECT_ALIAS, 300, 1'b0);
    start_i <= 1'b0;
    while (pending_norm_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Normalized %0d words across all count modes (%0d mode writes),", words_sent,
             mode_writes);
    $display("checked %0d results, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lzcns_pkg.sv
hdl/lzcns_norm_stage.sv
hdl/leading_zero_one_count_normalize_sticky.sv
sim/leading_zero_one_count_normalize_sticky_test.sv
